// File: sv/utf8cs_pkg.sv
package utf8cs_pkg;

	localparam logic [7:0] CtrlLimit    = 8'h20;
	localparam logic [7:0] DelByte      = 8'h7f;
	localparam logic [7:0] C1Low        = 8'h80;
	localparam logic [7:0] C1High       = 8'h9f;
	localparam logic [7:0] Lead2Low     = 8'hc2;
	localparam logic [7:0] Lead2High    = 8'hdf;
	localparam logic [7:0] Lead3Low     = 8'he0;
	localparam logic [7:0] Lead3High    = 8'hef;
	localparam logic [7:0] Lead4Low     = 8'hf0;
	localparam logic [7:0] Lead4High    = 8'hf4;
	localparam logic [7:0] ContHigh     = 8'hbf;
	localparam logic [7:0] SecondSplit  = 8'ha0;
	localparam logic [7:0] SecondLow4   = 8'h90;
	localparam logic [7:0] SecondHigh4  = 8'h8f;
	localparam logic [7:0] SurrogLead   = 8'hed;

	localparam int unsigned PointWidth  = 21;

	typedef struct packed {
		logic [7:0]            lead_value;
		logic [1:0]            bytes_expected;
		logic [1:0]            bytes_seen;
		logic [PointWidth-1:0] partial_point;
		logic                  bad_seen;
	} dec_state_t;

	localparam dec_state_t StateClear = '{
		lead_value:     8'h00,
		bytes_expected: 2'd0,
		bytes_seen:     2'd0,
		partial_point:  '0,
		bad_seen:       1'b0
	};

	function automatic logic is_control_point(input logic [PointWidth-1:0] cp);
		logic hit;
		begin
			hit = (cp < PointWidth'(CtrlLimit)) || (cp == PointWidth'(DelByte)) ||
				((cp >= PointWidth'(C1Low)) && (cp <= PointWidth'(C1High)));
			return hit;
		end
	endfunction

endpackage

// File: sv/utf8_control_char_screen.sv
// Screens a text string, one byte per transaction, for control characters
// and malformed UTF-8. A transaction with last_byte high closes the string
// and yields one verdict transaction (forbidden high for a bad string); other
// bytes yield none. A byte can be taken every clock while text_stall is low.
// It is registered, decoded combinationally against the sequence state, and
// the verdict lands in an output register, from which it is offered once its
// closing byte has left the input register. Bytes that do not close a string
// keep flowing while an earlier verdict waits to be taken. A closing byte is
// held in the input register until the output register is free.
module utf8_control_char_screen (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic       forbidden
);
	import utf8cs_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	dec_state_t state_q;
	dec_state_t state_next;
	logic       forbidden_next;
	logic       verdict_valid_q;
	logic       forbidden_q;
	logic       out_free;
	logic       adv_s1;

	assign out_free   = !verdict_valid_q || !verdict_stall;
	// bytes without a last mark never wait on the output side
	assign adv_s1     = valid_s1 && (!last_s1 || out_free);
	assign text_stall = valid_s1 && !adv_s1;

	utf8cs_decode u_decode (
		.state      (state_q),
		.text_byte  (byte_s1),
		.last_byte  (last_s1),
		.next_state (state_next),
		.forbidden  (forbidden_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_valid && !text_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StateClear;
		end else if (adv_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			forbidden_q <= forbidden_next;
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign forbidden     = forbidden_q;

	// decoder state is empty once a string is closed
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> state_q.bytes_expected == 2'd0 && !state_q.bad_seen)
		else $error("decoder state not cleared after last byte");

	// a pending verdict is never overwritten by the next one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid_q && verdict_stall && valid_s1 && last_s1 |-> !adv_s1)
		else $error("closing byte advanced over a stalled verdict");

	// a sequence in progress always has a multi-byte lead
	a_lead_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bytes_expected != 2'd0 |-> state_q.lead_value[7:6] == 2'b11
		&& !state_q.bad_seen)
		else $error("sequence in progress without a valid lead byte");

endmodule

// File: sv/utf8cs_decode.sv
module utf8cs_decode (
	input  utf8cs_pkg::dec_state_t state,
	input  logic [7:0]             text_byte,
	input  logic                   last_byte,
	output utf8cs_pkg::dec_state_t next_state,
	output logic                   forbidden
);
	import utf8cs_pkg::*;

	dec_state_t            work;
	logic                  bad;
	logic [PointWidth-1:0] cp_ext;
	logic [PointWidth-1:0] cp_new;

	always_comb begin
		work   = state;
		bad    = 1'b0;
		cp_ext = PointWidth'(text_byte);
		cp_new = {state.partial_point[PointWidth-7:0], text_byte[5:0]};
		if (!state.bad_seen) begin
			if (state.bytes_expected == 2'd0) begin
				// start of a sequence
				if (is_control_point(cp_ext)) begin
					bad = 1'b1;
				end else if (text_byte < C1Low) begin
					bad = 1'b0;
				end else if (text_byte >= Lead2Low && text_byte <= Lead2High) begin
					work.bytes_expected = 2'd1;
					work.partial_point  = PointWidth'(text_byte[4:0]);
					work.lead_value     = text_byte;
					work.bytes_seen     = 2'd0;
				end else if (text_byte >= Lead3Low && text_byte <= Lead3High) begin
					work.bytes_expected = 2'd2;
					work.partial_point  = PointWidth'(text_byte[3:0]);
					work.lead_value     = text_byte;
					work.bytes_seen     = 2'd0;
				end else if (text_byte >= Lead4Low && text_byte <= Lead4High) begin
					work.bytes_expected = 2'd3;
					work.partial_point  = PointWidth'(text_byte[2:0]);
					work.lead_value     = text_byte;
					work.bytes_seen     = 2'd0;
				end else begin
					bad = 1'b1;
				end
			end else begin
				// second byte limits: overlong, surrogate, above range
				if (state.bytes_seen == 2'd0 &&
					((state.lead_value == Lead3Low && text_byte < SecondSplit) ||
					(state.lead_value == SurrogLead && text_byte >= SecondSplit) ||
					(state.lead_value == Lead4Low && text_byte < SecondLow4) ||
					(state.lead_value == Lead4High && text_byte > SecondHigh4))) begin
					bad = 1'b1;
				end else if (text_byte < C1Low || text_byte > ContHigh) begin
					bad = 1'b1;
				end else begin
					work.partial_point  = cp_new;
					work.bytes_seen     = state.bytes_seen + 2'd1;
					work.bytes_expected = state.bytes_expected - 2'd1;
					if (work.bytes_expected == 2'd0) begin
						if (is_control_point(cp_new)) begin
							bad = 1'b1;
						end else begin
							work = StateClear;
						end
					end
				end
			end
			if (bad) begin
				work          = StateClear;
				work.bad_seen = 1'b1;
			end
		end

		forbidden = work.bad_seen || (work.bytes_expected != 2'd0);
		if (last_byte) begin
			next_state = StateClear;
		end else begin
			next_state = work;
		end
	end

endmodule
